/* rtl/coc_pkg.sv */
// ----------------------------------------------------------------------------
// Cylinder oscillation controller package
// Shared codes, widths and reset constants for the oscillation controller.
// ----------------------------------------------------------------------------
package coc_pkg;

  // Width of the stroke timeout register
  localparam int TIMEOUT_W = 20;

  // Timeout after reset, in ticks
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd10000;

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  // Cylinder motion
  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_IN   = 2'd1,
    MOT_OUT  = 2'd2
  } motion_t;

  // Fault codes
  typedef enum logic [1:0] {
    FLT_NONE   = 2'd0,
    FLT_BOTH   = 2'd1,
    FLT_TO_IN  = 2'd2,
    FLT_TO_OUT = 2'd3
  } fault_t;

endpackage

/* rtl/coc_in_if.sv */
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one command and the sampled limit switches.
// ----------------------------------------------------------------------------
interface coc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       switch_in;
  logic       switch_out;

  modport source (output valid, output op, output switch_in, output switch_out,
                  input ready);
  modport sink (input valid, input op, input switch_in, input switch_out,
                output ready);
endinterface

/* rtl/coc_out_if.sv */
// ----------------------------------------------------------------------------
// Status channel
// Valid/ready channel carrying valve drives, motion, run flag and fault code.
// ----------------------------------------------------------------------------
interface coc_out_if;
  logic       valid;
  logic       ready;
  logic       valve_in;
  logic       valve_out;
  logic [1:0] motion;
  logic       running;
  logic [1:0] fault_code;

  modport source (output valid, output valve_in, output valve_out, output motion,
                  output running, output fault_code, input ready);
  modport sink (input valid, input valve_in, input valve_out, input motion,
                input running, input fault_code, output ready);
endinterface

/* rtl/cylinder_oscillation_controller.sv */
// The status beat for an accepted command beat is registered and appears in the cycle after acceptance.
// Throughput: one command beat per cycle; the control state registers double
// as the status register, so a new beat is taken whenever the status slot is
// empty or being taken in the same cycle.
// Reset: motion stopped, oscillation disabled, stroke timer zero, no fault,
// timeout 10000 ticks, no status beat pending.
// ----------------------------------------------------------------------------
// Cylinder oscillation controller
// Drives a two-valve pneumatic cylinder between its limit switches with
// stroke timeout and switch fault detection.
// ----------------------------------------------------------------------------
module cylinder_oscillation_controller
  import coc_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [TIMEOUT_W-1:0] cfg_wr_data,
  coc_in_if.sink               in_ch,
  coc_out_if.source            out_ch
);

  localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

  logic [TIMEOUT_W-1:0]  timeout;
  motion_t               motion;
  motion_t               motion_next;
  logic                  enabled;
  logic                  enabled_next;
  logic [TIMER_BITS-1:0] elapsed;
  logic [TIMER_BITS-1:0] elapsed_next;
  logic [TIMER_BITS-1:0] elapsed_inc;
  fault_t                fault;
  fault_t                fault_next;
  logic                  out_valid;
  logic                  accept;
  logic                  both_sw;
  logic                  timed_out;

  // Take a beat when the status slot is free or draining
  assign in_ch.ready = ~out_valid | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  // Saturating stroke timer advance and timeout compare
  assign elapsed_inc = (elapsed == {TIMER_BITS{1'b1}}) ? elapsed
                                                       : elapsed + 1'b1;
  assign timed_out   = CMP_W'(elapsed_inc) > CMP_W'(timeout);
  assign both_sw     = in_ch.switch_in & in_ch.switch_out;

  // Next control state for the beat on the input
  always_comb begin
    motion_next  = motion;
    enabled_next = enabled;
    elapsed_next = elapsed;
    fault_next   = fault;
    unique case (op_t'(in_ch.op))
      OP_TICK: begin
        if (enabled) begin
          if (motion != MOT_STOP && timed_out) begin
            fault_next   = (motion == MOT_IN) ? FLT_TO_IN : FLT_TO_OUT;
            motion_next  = MOT_STOP;
            elapsed_next = '0;
            enabled_next = 1'b0;
          end else if (both_sw) begin
            fault_next   = FLT_BOTH;
            motion_next  = MOT_STOP;
            elapsed_next = '0;
            enabled_next = 1'b0;
          end else begin
            unique case (motion)
              MOT_IN: begin
                elapsed_next = elapsed_inc;
                if (in_ch.switch_in) begin
                  motion_next  = MOT_OUT;
                  elapsed_next = '0;
                end
              end
              MOT_OUT: begin
                elapsed_next = elapsed_inc;
                if (in_ch.switch_out) begin
                  motion_next  = MOT_IN;
                  elapsed_next = '0;
                end
              end
              default: begin
                motion_next  = in_ch.switch_in ? MOT_OUT : MOT_IN;
                elapsed_next = '0;
              end
            endcase
          end
        end
      end
      OP_START: begin
        elapsed_next = '0;
        if (both_sw) begin
          fault_next   = FLT_BOTH;
          motion_next  = MOT_STOP;
          enabled_next = 1'b0;
        end else begin
          fault_next   = FLT_NONE;
          motion_next  = in_ch.switch_in ? MOT_OUT : MOT_IN;
          enabled_next = 1'b1;
        end
      end
      OP_STOP: begin
        enabled_next = 1'b0;
        motion_next  = MOT_STOP;
        elapsed_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout <= cfg_wr_data;
    end
  end

  // Control state, advanced on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      motion  <= MOT_STOP;
      enabled <= 1'b0;
      elapsed <= '0;
      fault   <= FLT_NONE;
    end else if (accept) begin
      motion  <= motion_next;
      enabled <= enabled_next;
      elapsed <= elapsed_next;
      fault   <= fault_next;
    end
  end

  // Status beat valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Status payload straight from the control state
  assign out_ch.valid      = out_valid;
  assign out_ch.valve_in   = (motion == MOT_IN);
  assign out_ch.valve_out  = (motion == MOT_OUT);
  assign out_ch.motion     = motion;
  assign out_ch.running    = enabled;
  assign out_ch.fault_code = fault;

  // A moving cylinder is always enabled
  a_move_enabled: assert property (@(posedge clk) disable iff (rst)
    (motion != MOT_STOP) |-> enabled)
    else $error("cylinder moving while disabled");

  // The stroke timer only runs during a stroke
  a_timer_idle: assert property (@(posedge clk) disable iff (rst)
    (motion == MOT_STOP) |-> (elapsed == '0))
    else $error("stroke timer nonzero while stopped");

  // A start from the inner end begins an outward stroke
  a_start_out: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.op == OP_START && in_ch.switch_in && !in_ch.switch_out)
      |=> (motion == MOT_OUT && enabled && fault == FLT_NONE))
    else $error("start at inner end did not stroke outward");

  // Status holds while a beat is waiting
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> ($stable(motion) && $stable(fault)))
    else $error("status changed while beat pending");

endmodule
